@@ rtl/bde_pkg.sv @@
// Shared types, constants and register codes for the binary dilate/erode block.
`timescale 1ns / 1ps

package bde_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int SE_SIZE_DEF   = 3;
    localparam int MAX_HEIGHT    = 4096;

    localparam int IMG_W_BITS     = 11;
    localparam int IMG_H_BITS     = 13;
    localparam int MASK_BITS      = 9;
    localparam int ANCHOR_BITS    = 2;
    localparam int ROW_BITS       = 12;   // row of a result pixel, below MAX_HEIGHT
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 3;
    localparam int PIXEL_BITS     = 8;

    localparam logic [PIXEL_BITS-1:0] PIXEL_FG = 8'hFF;
    localparam logic [PIXEL_BITS-1:0] PIXEL_BG = 8'h00;

    localparam logic [IMG_W_BITS-1:0]  RST_IMAGE_WIDTH  = 11'd640;
    localparam logic [IMG_H_BITS-1:0]  RST_IMAGE_HEIGHT = 13'd480;
    localparam logic                   RST_OP_MODE      = 1'b0;
    localparam logic [MASK_BITS-1:0]   RST_ELEM_MASK    = 9'h1FF;
    localparam logic [ANCHOR_BITS-1:0] RST_ANCHOR_COL   = 2'd1;
    localparam logic [ANCHOR_BITS-1:0] RST_ANCHOR_ROW   = 2'd1;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_OP_MODE      = 3'd2,
        CFG_ELEM_MASK    = 3'd3,
        CFG_ANCHOR_COL   = 3'd4,
        CFG_ANCHOR_ROW   = 3'd5
    } t_cfg_index;

    typedef enum logic {
        OP_DILATE = 1'b0,
        OP_ERODE  = 1'b1
    } t_op_mode;

    // Per-request control handed from the sequencer into the pipe
    typedef struct packed {
        logic     fg;     // pixel bit written into the history
        logic     emit;   // request produces a result
        logic     last;   // result closes the frame
        t_op_mode mode;
        logic     kill;   // erosion touches a point outside the frame
    } t_item_ctl;

endpackage

@@ rtl/binary_dilate_erode.sv @@
// Top level: binary dilation / erosion over a raster pixel stream.
//
// Usage
//   Pixels enter on s_axis in raster order, one request per pixel; tuser[0] marks
//   a flush request that carries no pixel. A pixel is foreground when it is 255.
//   Results leave on m_axis as 255 or 0, with tlast on the final pixel of a frame.
//   The result of pixel p belongs to input request p + (SE_SIZE-1)*(width+1), so
//   that many flush requests after the frame's pixels drain it; the earliest
//   requests of a frame give no result.
//   Configuration is written through i_cfg_* while idle; the next frame picks it up.
// Timing
//   One request per clock while m_axis takes results. The request that releases
//   a result passes the stage-one register, window column cells and output register.
//   Row history sits in one memory of MAX_WIDTH words, (2*SE_SIZE-2) bits wide,
//   read and written once per request; the window is a chain of 2*SE_SIZE-1 cells.
// Reset and stall
//   Reset returns the registers to their defaults and starts a fresh frame;
//   the history memory is not cleared, taps from outside the frame are masked.
//   When m_axis stalls with a result held, the whole pipe holds and s_axis_tready
//   drops in the same cycle.
`timescale 1ns / 1ps

module binary_dilate_erode #(
    parameter int MAX_WIDTH = bde_pkg::MAX_WIDTH_DEF,
    parameter int SE_SIZE   = bde_pkg::SE_SIZE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bde_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [bde_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [7:0] pixel_in
    input  logic [0:0]                         s_axis_tuser,   // [0] flush_item
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [7:0]                         m_axis_tdata,   // [7:0] pixel_out
    output logic                               m_axis_tlast
);

    localparam int K  = 2 * SE_SIZE - 1;
    localparam int AW = $clog2(MAX_WIDTH);

    logic en, acc;

    bde_pkg::t_item_ctl ctl0;
    logic [AW-1:0]      cin0;
    logic [K*K-1:0]     sel0;

    // stage 1: request registered, history read in flight
    logic               r_v1;
    bde_pkg::t_item_ctl r_ctl1;
    logic [AW-1:0]      r_cin1;
    logic [K*K-1:0]     r_sel1;

    // stage 2: window holds the result pixel's neighbourhood
    logic               r_v2;
    logic               r_last2;
    bde_pkg::t_op_mode  r_mode2;
    logic               r_kill2;
    logic [K*K-1:0]     r_sel2;

    logic                           r_ov;
    logic [bde_pkg::PIXEL_BITS-1:0] r_opix;
    logic                           r_olast;

    logic [K-1:0]   new_col;
    logic [K-1:0]   cell_q [K];
    logic [K*K-1:0] win;
    logic           shift;
    logic           res;

    assign en    = !r_ov || m_axis_tready;
    assign acc   = s_axis_tvalid && en;
    assign shift = en && r_v1;

    bde_ctrl #(
        .MAX_WIDTH(MAX_WIDTH),
        .SE_SIZE  (SE_SIZE),
        .K        (K),
        .AW       (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_wdata(i_cfg_wdata),
        .i_adv      (acc),
        .i_pixel    (s_axis_tdata),
        .i_flush    (s_axis_tuser[0]),
        .o_ctl      (ctl0),
        .o_cin      (cin0),
        .o_sel      (sel0)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_ctl1 <= ctl0;
            r_cin1 <= cin0;
            r_sel1 <= sel0;
        end
    end

    // newest column: top tap is the incoming pixel, lower taps come from history
    generate
        if (SE_SIZE > 1) begin : g_hist
            localparam int LB = K - 1;
            logic [LB-1:0] hist_rd;
            logic [LB-1:0] hist_sh;

            assign hist_sh = {hist_rd[LB-2:0], r_ctl1.fg};

            bde_line_buf #(
                .DEPTH(MAX_WIDTH),
                .DW   (LB),
                .AW   (AW)
            ) u_line_buf (
                .i_clk    (i_clk),
                .i_rd_en  (acc),
                .i_rd_addr(cin0),
                .i_wr_en  (shift),
                .i_wr_addr(r_cin1),
                .i_wr_data(hist_sh),
                .o_rd_data(hist_rd)
            );

            always_comb begin
                new_col[K-1] = r_ctl1.fg;
                for (int m = 1; m < K; m++) begin
                    new_col[K-1-m] = hist_rd[m-1];
                end
            end
        end else begin : g_nohist
            assign new_col = r_ctl1.fg;
        end
    endgenerate

    generate
        for (genvar k = 0; k < K; k++) begin : g_cells
            if (k == 0) begin : g_head
                bde_cell #(.ROWS(K)) u_cell (
                    .i_clk  (i_clk),
                    .i_shift(shift),
                    .i_col  (new_col),
                    .o_col  (cell_q[k])
                );
            end else begin : g_link
                bde_cell #(.ROWS(K)) u_cell (
                    .i_clk  (i_clk),
                    .i_shift(shift),
                    .i_col  (cell_q[k-1]),
                    .o_col  (cell_q[k])
                );
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1 && r_ctl1.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_last2 <= r_ctl1.last;
            r_mode2 <= r_ctl1.mode;
            r_kill2 <= r_ctl1.kill;
            r_sel2  <= r_sel1;
        end
    end

    // cell k holds the column k requests old, i.e. window column K-1-k
    always_comb begin
        for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K; c++) begin
                win[r*K+c] = cell_q[K-1-c][r];
            end
        end
    end

    always_comb begin
        if (r_mode2 == bde_pkg::OP_ERODE) begin
            res = !r_kill2 && &(~r_sel2 | win);
        end else begin
            res = |(r_sel2 & win);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v2) begin
            r_opix  <= res ? bde_pkg::PIXEL_FG : bde_pkg::PIXEL_BG;
            r_olast <= r_last2;
        end
    end

    assign s_axis_tready = en;
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = r_opix;
    assign m_axis_tlast  = r_olast;

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov && !m_axis_tready |=> r_ov && $stable(r_opix) && $stable(r_olast))
        else $error("held result changed while the sink stalled");

    a_pixel_binary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_opix == bde_pkg::PIXEL_FG) || (r_opix == bde_pkg::PIXEL_BG))
        else $error("result pixel neither foreground nor background");

    a_request_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> r_v1)
        else $error("accepted request missing from stage one");

    a_pipe_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v1) && $stable(r_v2))
        else $error("pipe advanced during a stall");

endmodule

@@ rtl/bde_cell.sv @@
// One window column cell: holds a column of taps and passes it on per request.
`timescale 1ns / 1ps

module bde_cell #(
    parameter int ROWS = 5
) (
    input  logic            i_clk,
    input  logic            i_shift,
    input  logic [ROWS-1:0] i_col,
    output logic [ROWS-1:0] o_col
);

    logic [ROWS-1:0] r_col;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_col <= i_col;
        end
    end

    assign o_col = r_col;

endmodule

@@ rtl/bde_line_buf.sv @@
// Row history memory: read-before-write delay line with a same-address bypass.
`timescale 1ns / 1ps

module bde_line_buf #(
    parameter int DEPTH = 1024,
    parameter int DW    = 4,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    output logic [DW-1:0] o_rd_data
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_q;
    logic          r_bp;
    logic [DW-1:0] r_bp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // a write landing on the address being read wins (one-pixel rows)
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q       <= r_mem[i_rd_addr];
            r_bp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_bp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_bp ? r_bp_data : r_q;

endmodule

@@ rtl/bde_ctrl.sv @@
// Frame sequencer: config registers, frame latch, counters and window point select.
`timescale 1ns / 1ps

module bde_ctrl #(
    parameter int MAX_WIDTH = bde_pkg::MAX_WIDTH_DEF,
    parameter int SE_SIZE   = bde_pkg::SE_SIZE_DEF,
    parameter int K         = 2 * SE_SIZE - 1,
    parameter int AW        = $clog2(MAX_WIDTH)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [bde_pkg::CFG_INDEX_BITS-1:0] i_cfg_index,
    input  logic [bde_pkg::CFG_DATA_BITS-1:0]  i_cfg_wdata,
    input  logic                               i_adv,
    input  logic [bde_pkg::PIXEL_BITS-1:0]     i_pixel,
    input  logic                               i_flush,
    output bde_pkg::t_item_ctl                 o_ctl,
    output logic [AW-1:0]                      o_cin,
    output logic [K*K-1:0]                     o_sel
);

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int CW    = (WW > bde_pkg::IMG_W_BITS) ? WW : bde_pkg::IMG_W_BITS;
    localparam int HB    = bde_pkg::IMG_H_BITS;
    localparam int YW    = bde_pkg::ROW_BITS;
    localparam int RW    = $clog2(bde_pkg::MAX_HEIGHT + 2 * SE_SIZE);
    localparam int LATW  = $clog2((SE_SIZE - 1) * (MAX_WIDTH + 1) + 2);
    localparam int XS    = WW + 2;
    localparam int YS    = HB + 2;
    localparam int AB    = bde_pkg::ANCHOR_BITS;

    // configuration registers
    logic [bde_pkg::IMG_W_BITS-1:0] r_cfg_w;
    logic [HB-1:0]                  r_cfg_h;
    logic                           r_cfg_mode;
    logic [bde_pkg::MASK_BITS-1:0]  r_cfg_mask;
    logic [AB-1:0]                  r_cfg_cx;
    logic [AB-1:0]                  r_cfg_cy;

    // frame copy
    logic [WW-1:0]                  r_act_w;
    logic [HB-1:0]                  r_act_h;
    logic                           r_act_mode;
    logic [bde_pkg::MASK_BITS-1:0]  r_act_mask;
    logic [AB-1:0]                  r_act_cx;
    logic [AB-1:0]                  r_act_cy;
    logic [LATW-1:0]                r_act_lat;

    logic            r_first;
    logic [AW-1:0]   r_cin;
    logic [RW-1:0]   r_rin;
    logic [LATW-1:0] r_pre;
    logic [AW-1:0]   r_x;
    logic [YW-1:0]   r_y;

    logic [WW-1:0]                 w_sat, w_cur;
    logic [HB-1:0]                 h_sat, h_cur;
    logic [AB-1:0]                 cx_sat, cy_sat, cx_cur, cy_cur;
    logic [LATW-1:0]               lat_calc, lat_cur;
    logic                          mode_cur;
    logic [bde_pkg::MASK_BITS-1:0] mask_cur;

    logic [AW-1:0]   cur_cin, n_cin;
    logic [RW-1:0]   cur_rin, n_rin;
    logic [LATW-1:0] cur_pre, n_pre;
    logic [AW-1:0]   cur_x, n_x;
    logic [YW-1:0]   cur_y, n_y;
    logic [WW-1:0]   cin_p1, x_p1;
    logic            cin_wrap, x_wrap;
    logic            emit, last, fg;
    logic [K-1:0]    col_ok, row_ok;
    logic [K*K-1:0]  pt, sel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w    <= bde_pkg::RST_IMAGE_WIDTH;
            r_cfg_h    <= bde_pkg::RST_IMAGE_HEIGHT;
            r_cfg_mode <= bde_pkg::RST_OP_MODE;
            r_cfg_mask <= bde_pkg::RST_ELEM_MASK;
            r_cfg_cx   <= bde_pkg::RST_ANCHOR_COL;
            r_cfg_cy   <= bde_pkg::RST_ANCHOR_ROW;
        end else if (i_cfg_wr_en) begin
            unique case (bde_pkg::t_cfg_index'(i_cfg_index))
                bde_pkg::CFG_IMAGE_WIDTH:  r_cfg_w    <= i_cfg_wdata[bde_pkg::IMG_W_BITS-1:0];
                bde_pkg::CFG_IMAGE_HEIGHT: r_cfg_h    <= i_cfg_wdata[HB-1:0];
                bde_pkg::CFG_OP_MODE:      r_cfg_mode <= i_cfg_wdata[0];
                bde_pkg::CFG_ELEM_MASK:    r_cfg_mask <= i_cfg_wdata[bde_pkg::MASK_BITS-1:0];
                bde_pkg::CFG_ANCHOR_COL:   r_cfg_cx   <= i_cfg_wdata[AB-1:0];
                bde_pkg::CFG_ANCHOR_ROW:   r_cfg_cy   <= i_cfg_wdata[AB-1:0];
                default: ;
            endcase
        end
    end

    // saturated register values, taken at the first request of a frame
    always_comb begin
        if (r_cfg_w == '0) begin
            w_sat = WW'(1);
        end else if (CW'(r_cfg_w) > CW'(MAX_WIDTH)) begin
            w_sat = WW'(MAX_WIDTH);
        end else begin
            w_sat = WW'(r_cfg_w);
        end
        if (r_cfg_h == '0) begin
            h_sat = HB'(1);
        end else if (r_cfg_h > HB'(bde_pkg::MAX_HEIGHT)) begin
            h_sat = HB'(bde_pkg::MAX_HEIGHT);
        end else begin
            h_sat = r_cfg_h;
        end
        cx_sat   = (int'(r_cfg_cx) > SE_SIZE - 1) ? AB'(SE_SIZE - 1) : r_cfg_cx;
        cy_sat   = (int'(r_cfg_cy) > SE_SIZE - 1) ? AB'(SE_SIZE - 1) : r_cfg_cy;
        lat_calc = LATW'((SE_SIZE - 1) * (int'(w_sat) + 1));
    end

    always_comb begin
        w_cur    = r_first ? w_sat      : r_act_w;
        h_cur    = r_first ? h_sat      : r_act_h;
        mode_cur = r_first ? r_cfg_mode : r_act_mode;
        mask_cur = r_first ? r_cfg_mask : r_act_mask;
        cx_cur   = r_first ? cx_sat     : r_act_cx;
        cy_cur   = r_first ? cy_sat     : r_act_cy;
        lat_cur  = r_first ? lat_calc   : r_act_lat;
        cur_cin  = r_first ? '0 : r_cin;
        cur_rin  = r_first ? '0 : r_rin;
        cur_pre  = r_first ? '0 : r_pre;
        cur_x    = r_first ? '0 : r_x;
        cur_y    = r_first ? '0 : r_y;
    end

    // input position (newest pixel) and output position (result pixel)
    always_comb begin
        fg   = (cur_rin < RW'(h_cur)) && (i_pixel == bde_pkg::PIXEL_FG) && !i_flush;
        emit = (cur_pre == lat_cur);
        last = emit && (WW'(cur_x) == w_cur - WW'(1)) && (HB'(cur_y) == h_cur - HB'(1));

        cin_p1   = WW'(cur_cin) + WW'(1);
        cin_wrap = (cin_p1 == w_cur);
        n_cin    = cin_wrap ? '0 : AW'(cin_p1);
        n_rin    = cin_wrap ? cur_rin + RW'(1) : cur_rin;
        n_pre    = emit ? cur_pre : cur_pre + LATW'(1);

        x_p1   = WW'(cur_x) + WW'(1);
        x_wrap = (x_p1 == w_cur);
        n_x    = cur_x;
        n_y    = cur_y;
        if (emit) begin
            n_x = x_wrap ? '0 : AW'(x_p1);
            n_y = x_wrap ? cur_y + YW'(1) : cur_y;
        end
    end

    // which window taps the element touches, and which lie inside the frame
    always_comb begin
        logic signed [XS-1:0] px;
        logic signed [YS-1:0] py;
        int ii, jj, dx, dy, bp;
        for (int c = 0; c < K; c++) begin
            px = XS'(cur_x) + XS'(c) - XS'(SE_SIZE - 1);
            col_ok[c] = (px >= 0) && (px < $signed(XS'(w_cur)));
        end
        for (int r = 0; r < K; r++) begin
            py = YS'(cur_y) + YS'(r) - YS'(SE_SIZE - 1);
            row_ok[r] = (py >= 0) && (py < $signed(YS'(h_cur)));
        end
        for (int r = 0; r < K; r++) begin
            for (int c = 0; c < K; c++) begin
                dx = c - (SE_SIZE - 1);
                dy = r - (SE_SIZE - 1);
                if (mode_cur == bde_pkg::OP_ERODE) begin
                    ii = int'(cx_cur) + dx;
                    jj = int'(cy_cur) + dy;
                end else begin
                    ii = int'(cx_cur) - dx;
                    jj = int'(cy_cur) - dy;
                end
                bp = jj * SE_SIZE + ii;
                pt[r*K+c] = 1'b0;
                if (ii >= 0 && ii < SE_SIZE && jj >= 0 && jj < SE_SIZE
                        && bp < bde_pkg::MASK_BITS) begin
                    pt[r*K+c] = mask_cur[bp[3:0]];
                end
                sel[r*K+c] = pt[r*K+c] && col_ok[c] && row_ok[r];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
            r_cin   <= '0;
            r_rin   <= '0;
            r_pre   <= '0;
            r_x     <= '0;
            r_y     <= '0;
        end else if (i_adv) begin
            r_first <= last;
            r_cin   <= n_cin;
            r_rin   <= n_rin;
            r_pre   <= n_pre;
            r_x     <= n_x;
            r_y     <= n_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_w    <= '0;
            r_act_h    <= '0;
            r_act_mode <= 1'b0;
            r_act_mask <= '0;
            r_act_cx   <= '0;
            r_act_cy   <= '0;
            r_act_lat  <= '0;
        end else if (i_adv && r_first) begin
            r_act_w    <= w_sat;
            r_act_h    <= h_sat;
            r_act_mode <= r_cfg_mode;
            r_act_mask <= r_cfg_mask;
            r_act_cx   <= cx_sat;
            r_act_cy   <= cy_sat;
            r_act_lat  <= lat_calc;
        end
    end

    always_comb begin
        o_ctl.fg   = fg;
        o_ctl.emit = emit;
        o_ctl.last = last;
        o_ctl.mode = bde_pkg::t_op_mode'(mode_cur);
        o_ctl.kill = (mode_cur == bde_pkg::OP_ERODE) && |(pt & ~sel);
    end

    assign o_cin = cur_cin;
    assign o_sel = sel;

endmodule

@@ verif/tb_binary_dilate_erode.sv @@
// Testbench for binary_dilate_erode: stream stimulus, own prediction, result scoreboard.
`timescale 1ns / 1ps

module tb_binary_dilate_erode;
    import bde_pkg::*;

    // Predicts each result pixel from the accepted requests and checks the output stream
    class morph_scoreboard;
        localparam int SE   = SE_SIZE_DEF;
        localparam int HIST = 2 * (SE - 1) * (MAX_WIDTH_DEF + 1) + 1;

        typedef struct {
            logic [PIXEL_BITS-1:0] px;
            logic                  last;
        } t_result;

        // registers as written, and the copy latched at the first request of a frame
        logic [IMG_W_BITS-1:0]  reg_w;
        logic [IMG_H_BITS-1:0]  reg_h;
        t_op_mode               reg_mode;
        logic [MASK_BITS-1:0]   reg_mask;
        logic [ANCHOR_BITS-1:0] reg_cx, reg_cy;
        int                     cur_w, cur_h, cur_cx, cur_cy;
        t_op_mode               cur_mode;
        logic [MASK_BITS-1:0]   cur_mask;

        bit          history [HIST];
        int unsigned req_idx, col, row;
        t_result     expected_px [$];
        int          errors, checked, frames, requests;

        function new();
            reg_w    = RST_IMAGE_WIDTH;
            reg_h    = RST_IMAGE_HEIGHT;
            reg_mode = t_op_mode'(RST_OP_MODE);
            reg_mask = RST_ELEM_MASK;
            reg_cx   = RST_ANCHOR_COL;
            reg_cy   = RST_ANCHOR_ROW;
            req_idx  = 0;
            col      = 0;
            row      = 0;
            errors   = 0;
            checked  = 0;
            frames   = 0;
            requests = 0;
            foreach (history[k]) history[k] = 1'b0;
        endfunction

        function int eff_width(logic [IMG_W_BITS-1:0] w);
            if (w == 0) return 1;
            return (w > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(w);
        endfunction

        function int eff_height(logic [IMG_H_BITS-1:0] h);
            if (h == 0) return 1;
            return (h > MAX_HEIGHT) ? MAX_HEIGHT : int'(h);
        endfunction

        function void set_reg(t_cfg_index idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_IMAGE_WIDTH:  reg_w    = val[IMG_W_BITS-1:0];
                CFG_IMAGE_HEIGHT: reg_h    = val[IMG_H_BITS-1:0];
                CFG_OP_MODE:      reg_mode = t_op_mode'(val[0]);
                CFG_ELEM_MASK:    reg_mask = val[MASK_BITS-1:0];
                CFG_ANCHOR_COL:   reg_cx   = val[ANCHOR_BITS-1:0];
                CFG_ANCHOR_ROW:   reg_cy   = val[ANCHOR_BITS-1:0];
                default: ;
            endcase
        endfunction

        // pixel count and drain length of the next frame under the current registers
        function void frame_shape(output int unsigned n, output int unsigned lat);
            n   = eff_width(reg_w) * eff_height(reg_h);
            lat = (SE - 1) * (eff_width(reg_w) + 1);
        endfunction

        function bit tap(int qx, int qy);
            if (qx < 0 || qy < 0 || qx >= cur_w || qy >= cur_h) return 1'b0;
            return history[(qy * cur_w + qx) % HIST];
        endfunction

        function bit window_hit(int x, int y);
            bit acc;
            acc = (cur_mode == OP_ERODE);
            for (int j = 0; j < SE; j++) begin
                for (int i = 0; i < SE; i++) begin
                    if (j * SE + i < MASK_BITS && cur_mask[j * SE + i]) begin
                        if (cur_mode == OP_DILATE)
                            acc = acc | tap(x + cur_cx - i, y + cur_cy - j);
                        else
                            acc = acc & tap(x + i - cur_cx, y + j - cur_cy);
                    end
                end
            end
            return acc;
        endfunction

        function void note_request(logic [PIXEL_BITS-1:0] px, logic flush);
            int unsigned n, lat, t;
            t_result     r;
            requests++;
            if (req_idx == 0) begin
                cur_w    = eff_width(reg_w);
                cur_h    = eff_height(reg_h);
                cur_mode = reg_mode;
                cur_mask = reg_mask;
                cur_cx   = (reg_cx > SE - 1) ? SE - 1 : int'(reg_cx);
                cur_cy   = (reg_cy > SE - 1) ? SE - 1 : int'(reg_cy);
                col      = 0;
                row      = 0;
            end
            n   = cur_w * cur_h;
            lat = (SE - 1) * (cur_w + 1);
            t   = req_idx;
            // a flush request inside the pixel phase counts as background
            if (t < n) history[t % HIST] = (px == PIXEL_FG) && !flush;
            if (t < lat) begin
                req_idx = t + 1;
                return;
            end
            r.px   = window_hit(col, row) ? PIXEL_FG : PIXEL_BG;
            r.last = (t - lat == n - 1);
            expected_px.push_back(r);
            if (r.last) begin
                req_idx = 0;
                frames++;
            end else begin
                req_idx = t + 1;
                if (col + 1 >= cur_w) begin
                    col = 0;
                    row++;
                end else begin
                    col++;
                end
            end
        endfunction

        task report(string what);
            $display("MISMATCH @%0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [PIXEL_BITS-1:0] px, logic last);
            t_result r;
            if (expected_px.size() == 0) begin
                report($sformatf("unexpected result pixel %0d last %0b", px, last));
                return;
            end
            r = expected_px.pop_front();
            checked++;
            if (px !== r.px)
                report($sformatf("result %0d: pixel %0d, expected %0d", checked, px, r.px));
            if (last !== r.last)
                report($sformatf("result %0d: last %0b, expected %0b", checked, last, r.last));
        endtask

        function int pending();
            return expected_px.size();
        endfunction
    endclass

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] i_cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_wdata = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [7:0]                s_axis_tdata = '0;   // [7:0] pixel_in
    logic [0:0]                s_axis_tuser = '0;   // [0] flush_item
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [7:0]                m_axis_tdata;        // [7:0] pixel_out
    logic                      m_axis_tlast;

    morph_scoreboard sb;
    bit              calm = 1'b0;   // no idling on either side while set

    // directed frame, 4x3: {flush, pixel}; twelve pixels then ten drain requests
    logic [8:0] directed_reqs [22] = '{
        9'h0FF, 9'h000, 9'h0FF, 9'h0FE, 9'h07F, 9'h0FF, 9'h080, 9'h0FF,
        9'h1FF, 9'h0FF, 9'h001, 9'h0FF,
        9'h100, 9'h1FF, 9'h0FF, 9'h100, 9'h155, 9'h055, 9'h100, 9'h1AA,
        9'h100, 9'h100
    };

    binary_dilate_erode DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 15);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata, m_axis_tlast);
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_req(input logic [7:0] px, input logic flush);
        while (!calm && $urandom_range(99) < 15) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = px;
        s_axis_tuser  = flush;
        while (1) begin
            @(posedge i_clk);
            if (s_axis_tready) break;
        end
        sb.note_request(px, flush);
        @(negedge i_clk);
    endtask

    // leaves the enable high; the caller lowers it after the last write
    task automatic write_reg(input t_cfg_index idx, input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        sb.set_reg(idx, val);
        @(negedge i_clk);
    endtask

    task automatic configure_phase(input int k);
        logic [CFG_DATA_BITS-1:0] junk;
        int unsigned w, h, cx, cy, msk;
        t_op_mode    mode;
        bit          all;
        junk = CFG_DATA_BITS'($urandom);
        all  = (k % 2 == 1) && (k <= 9);
        w    = $urandom_range(8, 1);
        h    = $urandom_range(6, 1);
        mode = t_op_mode'($urandom_range(1));
        msk  = $urandom_range(3) == 0 ? ($urandom_range(1) ? 511 : 0) : $urandom_range(511);
        cx   = $urandom_range(3);
        cy   = $urandom_range(3);
        // zero sizes, anchor clamping and thin frames
        case (k)
            1: begin w = 0; h = 0; mode = OP_ERODE;  msk = 0;   cx = 0; cy = 0; end
            3: begin w = 8; h = 1; mode = OP_DILATE; cx = 0; cy = 2; end
            5: begin w = 1; h = 1; mode = OP_ERODE;  msk = 511; cx = 3; cy = 3; end
            7: begin w = 1; h = 6; mode = OP_DILATE; msk = 0;   cx = 2; cy = 0; end
            9: begin w = 2; h = 6; mode = OP_ERODE;  cx = 3; cy = 1; end
            default: ;
        endcase
        if (all || $urandom_range(4) != 0)
            write_reg(CFG_IMAGE_WIDTH, {junk[CFG_DATA_BITS-1:IMG_W_BITS], w[IMG_W_BITS-1:0]});
        if (all || $urandom_range(4) != 0)
            write_reg(CFG_IMAGE_HEIGHT, h[CFG_DATA_BITS-1:0]);
        if (all || $urandom_range(4) != 0)
            write_reg(CFG_OP_MODE, {junk[CFG_DATA_BITS-1:1], mode});
        if (all || $urandom_range(4) != 0)
            write_reg(CFG_ELEM_MASK, {junk[CFG_DATA_BITS-1:MASK_BITS], msk[MASK_BITS-1:0]});
        if (all || $urandom_range(4) != 0)
            write_reg(CFG_ANCHOR_COL, {junk[CFG_DATA_BITS-1:ANCHOR_BITS], cx[ANCHOR_BITS-1:0]});
        if (all || $urandom_range(4) != 0)
            write_reg(CFG_ANCHOR_ROW, {junk[CFG_DATA_BITS-1:ANCHOR_BITS], cy[ANCHOR_BITS-1:0]});
        i_cfg_wr_en = 1'b0;
    endtask

    // whole frame: pixels with a few stray flushes, then drain with a few plain requests
    task automatic run_frame(input int unsigned n, input int unsigned lat, input int fg_pct);
        logic [7:0] px;
        logic       flush;
        for (int unsigned t = 0; t < n + lat; t++) begin
            px = ($urandom_range(99) < fg_pct) ? PIXEL_FG : 8'($urandom_range(255));
            if (t < n)
                flush = ($urandom_range(99) < 6);
            else
                flush = ($urandom_range(99) >= 8);
            send_req(px, flush);
        end
        s_axis_tvalid = 1'b0;
    endtask

    // every result in, then a further wait for requests still in the pipe
    task automatic drain_wait();
        while (sb.pending() > 0) @(posedge i_clk);
        repeat (10) @(negedge i_clk);
    endtask

    initial begin
        int unsigned n, lat, rand_reqs;
        int          k, fg_sel;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed frame: only the size is written, the rest stays at reset values
        write_reg(CFG_IMAGE_WIDTH, 13'd4);
        write_reg(CFG_IMAGE_HEIGHT, 13'd3);
        i_cfg_wr_en = 1'b0;
        foreach (directed_reqs[d]) send_req(directed_reqs[d][7:0], directed_reqs[d][8]);
        s_axis_tvalid = 1'b0;
        drain_wait();

        rand_reqs = 0;
        k = 0;
        while (rand_reqs < 950) begin
            calm = (k >= 20 && k < 28);
            configure_phase(k);
            sb.frame_shape(n, lat);
            fg_sel = $urandom_range(2);
            run_frame(n, lat, fg_sel == 0 ? 20 : (fg_sel == 1 ? 50 : 85));
            rand_reqs += n + lat;
            drain_wait();
            k++;
        end
        calm = 1'b0;

        $display("Run covered %0d frames, %0d requests and %0d checked result pixels,",
                 sb.frames, sb.requests, sb.checked);
        $display("dilation and erosion, empty/full/random elements, zero sizes, clamped anchors.");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
